// File: sv/sfc_pkg.sv
// shared types, constants and the crc-8 byte update for the status frame checker
`default_nettype none

package sfc_pkg;

    // frame layout
    localparam int          FRAME_BYTES   = 9;
    localparam int          IDX_W         = 4;
    localparam logic [3:0]  POS_START     = 4'd0;
    localparam logic [3:0]  POS_COMMAND   = 4'd1;
    localparam logic [3:0]  POS_NETWORK   = 4'd2;
    localparam logic [3:0]  POS_AUX       = 4'd3;
    localparam logic [3:0]  POS_PAYLOAD   = 4'd4;
    localparam logic [3:0]  POS_CRC       = 4'd8;
    localparam logic [3:0]  POS_FULL      = 4'd9;

    // crc-8, msb first
    localparam logic [7:0]  CRC_POLY      = 8'h07;
    localparam logic [7:0]  CRC_INIT      = 8'h00;

    // command byte split
    localparam int          CODE_BITS_DEF = 4;

    // register bus
    localparam int          APB_ADDR_W    = 5;
    localparam int          APB_DATA_W    = 32;
    localparam int          REG_IDX_W     = 3;

    // register indexes
    localparam logic [2:0]  REG_START_VALUE      = 3'd0;
    localparam logic [2:0]  REG_NETWORK_ID       = 3'd1;
    localparam logic [2:0]  REG_PROTOCOL_VERSION = 3'd2;
    localparam logic [2:0]  REG_PING_CODE        = 3'd3;
    localparam logic [2:0]  REG_STATE_ALL_CODE   = 3'd4;
    localparam logic [2:0]  REG_TELEMETRY_CODE   = 3'd5;

    // register reset values
    localparam logic [3:0]  PING_CODE_RST      = 4'd0;
    localparam logic [3:0]  STATE_ALL_CODE_RST = 4'd1;
    localparam logic [3:0]  TELEMETRY_CODE_RST = 4'd2;

    // configuration handed to the frame core
    typedef struct packed {
        logic [7:0] start_value;
        logic [7:0] network_id;
        logic [3:0] protocol_version;
        logic [3:0] ping_code;
        logic [3:0] state_all_code;
        logic [3:0] telemetry_code;
    } sfc_cfg_t;

    // one byte through the crc-8 register, bit by bit
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/sfc_if.sv
// valid/ready channels for received bytes and frame results
`default_nettype none

interface sfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       buffer_end;

    modport source (output valid, output rx_byte, output buffer_end, input ready);
    modport sink   (input valid, input rx_byte, input buffer_end, output ready);
endinterface

interface sfc_out_if;
    logic        valid;
    logic        ready;
    logic        frame_ok;
    logic [3:0]  command_code;
    logic [7:0]  aux_value;
    logic [31:0] payload_word;

    modport source (output valid, output frame_ok, output command_code,
                    output aux_value, output payload_word, input ready);
    modport sink   (input valid, input frame_ok, input command_code,
                    input aux_value, input payload_word, output ready);
endinterface

`default_nettype wire

// File: sv/sfc_cfg_regs.sv
// register bank behind the apb-style configuration port
`default_nettype none

module sfc_cfg_regs
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sfc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sfc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sfc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output sfc_pkg::sfc_cfg_t                   cfg
);

    sfc_pkg::sfc_cfg_t cfg_reg;
    logic [sfc_pkg::REG_IDX_W-1:0] reg_idx;
    logic wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[sfc_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_value      <= '0;
            cfg_reg.network_id       <= '0;
            cfg_reg.protocol_version <= '0;
            cfg_reg.ping_code        <= sfc_pkg::PING_CODE_RST;
            cfg_reg.state_all_code   <= sfc_pkg::STATE_ALL_CODE_RST;
            cfg_reg.telemetry_code   <= sfc_pkg::TELEMETRY_CODE_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                sfc_pkg::REG_START_VALUE:      cfg_reg.start_value      <= pwdata[7:0];
                sfc_pkg::REG_NETWORK_ID:       cfg_reg.network_id       <= pwdata[7:0];
                sfc_pkg::REG_PROTOCOL_VERSION: cfg_reg.protocol_version <= pwdata[3:0];
                sfc_pkg::REG_PING_CODE:        cfg_reg.ping_code        <= pwdata[3:0];
                sfc_pkg::REG_STATE_ALL_CODE:   cfg_reg.state_all_code   <= pwdata[3:0];
                sfc_pkg::REG_TELEMETRY_CODE:   cfg_reg.telemetry_code   <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // read-back mux
    always_comb
    begin
        unique case (reg_idx)
            sfc_pkg::REG_START_VALUE:      prdata = {24'd0, cfg_reg.start_value};
            sfc_pkg::REG_NETWORK_ID:       prdata = {24'd0, cfg_reg.network_id};
            sfc_pkg::REG_PROTOCOL_VERSION: prdata = {28'd0, cfg_reg.protocol_version};
            sfc_pkg::REG_PING_CODE:        prdata = {28'd0, cfg_reg.ping_code};
            sfc_pkg::REG_STATE_ALL_CODE:   prdata = {28'd0, cfg_reg.state_all_code};
            sfc_pkg::REG_TELEMETRY_CODE:   prdata = {28'd0, cfg_reg.telemetry_code};
            default:                       prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: sv/sfc_frame_core.sv
// input register, per-buffer frame state with crc-8 update, and result register
`default_nettype none

module sfc_frame_core
#(
    parameter int CODE_BITS = sfc_pkg::CODE_BITS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire sfc_pkg::sfc_cfg_t cfg,
    sfc_in_if.sink            in_ch,
    sfc_out_if.source         out_ch
);

    localparam logic [7:0] CODE_MASK = 8'((16'd1 << CODE_BITS) - 16'd1);

    // input stage
    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_end_reg;
    logic       advance;

    // per-buffer state
    logic [sfc_pkg::IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [7:0]  crc_running_reg, crc_running_next;
    logic        start_bad_reg, start_bad_next;
    logic        check_fail_reg, check_fail_next;
    logic [15:0] header_store_reg, header_store_next;
    logic [31:0] payload_store_reg, payload_store_next;

    // result stage
    logic        out_valid_reg;
    logic        frame_ok_reg;
    logic [3:0]  command_code_reg;
    logic [7:0]  aux_value_reg;
    logic [31:0] payload_word_reg;

    logic [7:0] cmd;
    logic [7:0] code;
    logic [7:0] ver;
    logic       code_hit;
    logic       ok;

    assign advance     = s1_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_byte_reg <= in_ch.rx_byte;
            s1_end_reg  <= in_ch.buffer_end;
        end
    end

    // byte update by position in the frame
    always_comb
    begin
        byte_index_next    = byte_index_reg;
        crc_running_next   = crc_running_reg;
        start_bad_next     = start_bad_reg;
        check_fail_next    = check_fail_reg;
        header_store_next  = header_store_reg;
        payload_store_next = payload_store_reg;
        if (byte_index_reg < sfc_pkg::POS_FULL)
        begin
            byte_index_next = byte_index_reg + 4'd1;
            if (byte_index_reg < sfc_pkg::POS_CRC)
                crc_running_next = sfc_pkg::crc8_byte(crc_running_reg, s1_byte_reg);
            if (byte_index_reg == sfc_pkg::POS_START)
                start_bad_next = (s1_byte_reg != cfg.start_value);
            else if (byte_index_reg == sfc_pkg::POS_COMMAND)
                header_store_next[7:0] = s1_byte_reg;
            else if (byte_index_reg == sfc_pkg::POS_NETWORK)
            begin
                if (s1_byte_reg != cfg.network_id)
                    check_fail_next = 1'b1;
            end
            else if (byte_index_reg == sfc_pkg::POS_AUX)
                header_store_next[15:8] = s1_byte_reg;
            else if (byte_index_reg < sfc_pkg::POS_CRC)
            begin
                case (byte_index_reg[1:0])
                    2'd0:    payload_store_next[7:0]   = s1_byte_reg;
                    2'd1:    payload_store_next[15:8]  = s1_byte_reg;
                    2'd2:    payload_store_next[23:16] = s1_byte_reg;
                    default: payload_store_next[31:24] = s1_byte_reg;
                endcase
            end
            else
            begin
                if (s1_byte_reg != crc_running_reg)
                    check_fail_next = 1'b1;
            end
        end
    end

    // frame verdict from the updated state
    always_comb
    begin
        cmd      = header_store_next[7:0];
        code     = cmd & CODE_MASK;
        ver      = cmd >> CODE_BITS;
        code_hit = (code == {4'd0, cfg.ping_code})
                || (code == {4'd0, cfg.state_all_code})
                || (code == {4'd0, cfg.telemetry_code});
        ok       = (byte_index_next == sfc_pkg::POS_FULL) && !start_bad_next
                && !check_fail_next && (ver == {4'd0, cfg.protocol_version}) && code_hit;
    end

    // per-buffer state, cleared after the last byte of a buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= '0;
            crc_running_reg <= sfc_pkg::CRC_INIT;
            start_bad_reg   <= 1'b0;
            check_fail_reg  <= 1'b0;
        end
        else if (advance)
        begin
            if (s1_end_reg)
            begin
                byte_index_reg  <= '0;
                crc_running_reg <= sfc_pkg::CRC_INIT;
                start_bad_reg   <= 1'b0;
                check_fail_reg  <= 1'b0;
            end
            else
            begin
                byte_index_reg  <= byte_index_next;
                crc_running_reg <= crc_running_next;
                start_bad_reg   <= start_bad_next;
                check_fail_reg  <= check_fail_next;
            end
        end
    end

    // captured fields, only read once all nine bytes are in
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            header_store_reg  <= header_store_next;
            payload_store_reg <= payload_store_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && s1_end_reg)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_end_reg)
        begin
            frame_ok_reg     <= ok;
            command_code_reg <= ok ? code[3:0] : 4'd0;
            aux_value_reg    <= ok ? header_store_next[15:8] : 8'd0;
            payload_word_reg <= ok ? payload_store_next : 32'd0;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.frame_ok     = frame_ok_reg;
    assign out_ch.command_code = command_code_reg;
    assign out_ch.aux_value    = aux_value_reg;
    assign out_ch.payload_word = payload_word_reg;

endmodule

`default_nettype wire

// File: sv/status_frame_checker_crc8.sv
// top level of the status frame checker
//
// Takes one received byte per cycle while no held result stalls the input, and
// checks a nine-byte status frame: start byte, command byte (version in the upper
// bits, code in the lower CODE_BITS bits), network id, aux byte, four payload bytes
// and a CRC-8 (poly 0x07, init 0, msb first) over the first eight bytes. One result
// item comes out for each byte marked buffer_end; bytes past the ninth are ignored.
// An accepted byte passes the input register, the combinational byte update (unrolled
// crc-8 and field capture) and the result register. Rejected frames report zero in
// every result field. The user must write configuration through the apb-style port
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module status_frame_checker_crc8
#(
    parameter int CODE_BITS = sfc_pkg::CODE_BITS_DEF
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    sfc_in_if.sink                              in_ch,
    sfc_out_if.source                           out_ch,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sfc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sfc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sfc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready
);

    sfc_pkg::sfc_cfg_t cfg;

    // configuration registers
    sfc_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // frame datapath
    sfc_frame_core
    #(
        .CODE_BITS (CODE_BITS)
    )
    u_frame_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

`default_nettype wire

// File: sv/sfc_checker.sv
// port-level assertions for the status frame checker, bound to the top level
`default_nettype none

module sfc_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_buffer_end,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        out_frame_ok,
    input wire logic [3:0]  out_command_code,
    input wire logic [7:0]  out_aux_value,
    input wire logic [31:0] out_payload_word,
    input wire logic        pready
);

    // a held result keeps its valid and its verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_frame_ok))
        else $error("stalled result dropped or changed");

    // a rejected frame shows no fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_frame_ok |->
            out_command_code == 4'd0 && out_aux_value == 8'd0 && out_payload_word == 32'd0)
        else $error("rejected frame carries non-zero fields");

    // a new result follows an accepted byte marked buffer_end
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_buffer_end, 2))
        else $error("result without a marked last byte");

    // the register port never waits
    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind status_frame_checker_crc8 sfc_checker u_sfc_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_buffer_end    (in_ch.buffer_end),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_frame_ok     (out_ch.frame_ok),
    .out_command_code (out_ch.command_code),
    .out_aux_value    (out_ch.aux_value),
    .out_payload_word (out_ch.payload_word),
    .pready           (pready)
);

`default_nettype wire
